// ===== rtl/jecf_pkg.sv =====
// Shared types, codes and helper functions for the JSON escape and CRC-16 framer.
// Used by the front, queue and back modules and by the top level; depends on nothing.
`default_nettype none

package jecf_pkg;

	localparam int COUNT_WIDTH = 32;
	localparam int FIELD_WIDTH = 32;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int STEP_W = 4;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_LOW_B = 8'h62;
	localparam logic [7:0] CH_LOW_C = 8'h63;
	localparam logic [7:0] CH_LOW_F = 8'h66;
	localparam logic [7:0] CH_LOW_N = 8'h6E;
	localparam logic [7:0] CH_LOW_R = 8'h72;
	localparam logic [7:0] CH_LOW_T = 8'h74;
	localparam logic [7:0] CH_LOW_U = 8'h75;
	localparam logic [7:0] CTRL_LIMIT = 8'h20;

	typedef logic [COUNT_WIDTH-1:0] count_t;
	typedef logic [STEP_W-1:0] step_t;

	typedef enum logic [1:0] {
		FUNC_START   = 2'd0,
		FUNC_LITERAL = 2'd1,
		FUNC_ESCAPED = 2'd2,
		FUNC_END     = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		JOB_START = 3'd0,
		JOB_PLAIN = 3'd1,
		JOB_ESC2  = 3'd2,
		JOB_ESCU  = 3'd3,
		JOB_TRAIL = 3'd4
	} job_kind_t;

	typedef struct packed {
		job_kind_t kind;
		logic [7:0] data;
	} job_t;

	localparam step_t LAST_ESC2 = step_t'(1);
	localparam step_t LAST_ESCU = step_t'(5);
	localparam step_t LAST_TRAIL = step_t'(12);

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		return (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h57 + {4'h0, n});
	endfunction

	function automatic logic [15:0] crc_fold(input logic [15:0] acc, input logic [7:0] b);
		logic [15:0] r;
		r = acc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
		end
		return r;
	endfunction

	function automatic logic [FIELD_WIDTH-1:0] count_field(input count_t c);
		logic [63:0] w;
		w = 64'(c);
		return (w > 64'h0000_0000_FFFF_FFFF) ? '1 : w[FIELD_WIDTH-1:0];
	endfunction

	function automatic step_t job_last(input job_kind_t k);
		case (k)
			JOB_ESC2:  return LAST_ESC2;
			JOB_ESCU:  return LAST_ESCU;
			JOB_TRAIL: return LAST_TRAIL;
			default:   return '0;
		endcase
	endfunction

	function automatic logic [7:0] job_byte(input job_t j, input step_t s,
			input logic [15:0] crc);
		logic [7:0] t;
		t = j.data;
		case (j.kind)
			JOB_START: t = CH_LBRACE;
			JOB_PLAIN: t = j.data;
			JOB_ESC2:  t = (s == '0) ? CH_BSLASH : j.data;
			JOB_ESCU: begin
				case (s)
					4'd0:    t = CH_BSLASH;
					4'd1:    t = CH_LOW_U;
					4'd2:    t = CH_ZERO;
					4'd3:    t = CH_ZERO;
					4'd4:    t = hex_char(j.data[7:4]);
					default: t = hex_char(j.data[3:0]);
				endcase
			end
			JOB_TRAIL: begin
				case (s)
					4'd0:    t = CH_QUOTE;
					4'd1:    t = CH_LOW_C;
					4'd2:    t = CH_LOW_R;
					4'd3:    t = CH_LOW_C;
					4'd4:    t = CH_QUOTE;
					4'd5:    t = CH_COLON;
					4'd6:    t = CH_QUOTE;
					4'd7:    t = hex_char(crc[15:12]);
					4'd8:    t = hex_char(crc[11:8]);
					4'd9:    t = hex_char(crc[7:4]);
					4'd10:   t = hex_char(crc[3:0]);
					4'd11:   t = CH_QUOTE;
					default: t = CH_RBRACE;
				endcase
			end
			default: t = j.data;
		endcase
		return t;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/jecf_front.sv =====
// Front end: maps an input word to an output job (start, plain, escape, trailer).
// Depends on jecf_pkg.
`default_nettype none

module jecf_front import jecf_pkg::*; (
	input  wire logic [1:0] func,
	input  wire logic [7:0] data_byte,
	output job_t            job
);

	always_comb begin
		job.kind = JOB_PLAIN;
		job.data = data_byte;
		case (func_t'(func))
			FUNC_START:   job.kind = JOB_START;
			FUNC_LITERAL: job.kind = JOB_PLAIN;
			FUNC_ESCAPED: begin
				case (data_byte)
					CH_QUOTE:  job.kind = JOB_ESC2;
					CH_BSLASH: job.kind = JOB_ESC2;
					8'h08: begin
						job.kind = JOB_ESC2;
						job.data = CH_LOW_B;
					end
					8'h0C: begin
						job.kind = JOB_ESC2;
						job.data = CH_LOW_F;
					end
					8'h0A: begin
						job.kind = JOB_ESC2;
						job.data = CH_LOW_N;
					end
					8'h0D: begin
						job.kind = JOB_ESC2;
						job.data = CH_LOW_R;
					end
					8'h09: begin
						job.kind = JOB_ESC2;
						job.data = CH_LOW_T;
					end
					default: job.kind = (data_byte < CTRL_LIMIT) ? JOB_ESCU : JOB_PLAIN;
				endcase
			end
			FUNC_END: job.kind = JOB_TRAIL;
			default:  job.kind = JOB_PLAIN;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/jecf_queue.sv =====
// Short job queue between the front end and the back end.
// Depends on jecf_pkg.
`default_nettype none

module jecf_queue import jecf_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t push_job,
	output logic      full,
	input  wire logic pop,
	output logic      head_valid,
	output job_t      head_job
);

	job_t               slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;

	assign full = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job = slot_q[rd_ptr_q];

	function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/jecf_back.sv =====
// Back end: steps through each job one output byte per cycle unless stalled, keeps
// the CRC and byte count, holds the result in an output register. Uses jecf_pkg.
`default_nettype none

module jecf_back import jecf_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        head_valid,
	input  wire job_t        head_job,
	output logic             pop,
	output logic             res_valid,
	input  wire logic        res_ready,
	output logic [7:0]       out_byte,
	output logic             last_of_run,
	output logic [FIELD_WIDTH-1:0] byte_count
);

	step_t        step_q;
	logic [15:0]  crc_q;
	count_t       total_q;
	logic         valid_q;
	logic [7:0]   byte_q;
	logic         last_q;
	logic [FIELD_WIDTH-1:0] field_q;

	logic         fire;
	logic         at_last;
	logic [7:0]   cur_byte;
	logic [15:0]  crc_base;
	count_t       total_base;
	count_t       total_next;
	logic         starting;

	assign starting = (head_job.kind == JOB_START);
	assign fire = head_valid && (!valid_q || res_ready);
	assign at_last = (step_q == job_last(head_job.kind));
	assign pop = fire && at_last;
	assign crc_base = starting ? '0 : crc_q;
	assign total_base = starting ? '0 : total_q;
	assign total_next = (total_base == '1) ? total_base : total_base + 1'b1;
	assign cur_byte = job_byte(head_job, step_q, crc_q);

	always_ff @(posedge clk) begin
		if (fire) begin
			byte_q <= cur_byte;
			last_q <= at_last;
			field_q <= count_field(total_next);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			crc_q <= '0;
			total_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (fire) begin
				valid_q <= 1'b1;
				step_q <= at_last ? '0 : step_q + 1'b1;
				total_q <= total_next;
				if (head_job.kind != JOB_TRAIL) begin
					crc_q <= crc_fold(crc_base, cur_byte);
				end
			end else if (res_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = valid_q;
	assign out_byte = byte_q;
	assign last_of_run = last_q;
	assign byte_count = field_q;

endmodule

`default_nettype wire

// ===== rtl/json_escape_crc16_framer.sv =====
// Top level of the JSON escape framer with CRC-16/XMODEM trailer.
// Depends on jecf_pkg, jecf_front, jecf_queue and jecf_back.
//
//   channel | handshake              | payload
//   item    | item_valid, item_ready | func, data_byte
//   res     | res_valid, res_ready   | out_byte, last_of_run, byte_count
//
// The back end emits one output byte per cycle unless stalled; each item expands to
// 1 byte for a plain byte or the start, 2 or 6 for an escape, 13 for the trailer.
// Two jobs fit in the queue, so input is taken while a result waits until it is full.
// Reset clears the CRC, the byte count and the queue; no clearing pass is needed.
// A stalled result holds its register and the queue fills behind it.
`default_nettype none

module json_escape_crc16_framer import jecf_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_ready,
	input  wire logic [1:0]  func,
	input  wire logic [7:0]  data_byte,
	output logic             res_valid,
	input  wire logic        res_ready,
	output logic [7:0]       out_byte,
	output logic             last_of_run,
	output logic [31:0]      byte_count
);

	job_t  new_job;
	job_t  head_job;
	logic  q_full;
	logic  head_valid;
	logic  pop;

	jecf_front u_front (
		.func      (func),
		.data_byte (data_byte),
		.job       (new_job)
	);

	assign item_ready = !q_full;

	jecf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (item_valid && item_ready),
		.push_job   (new_job),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	jecf_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_job    (head_job),
		.pop         (pop),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.out_byte    (out_byte),
		.last_of_run (last_of_run),
		.byte_count  (byte_count)
	);

endmodule

`default_nettype wire

// ===== rtl/jecf_checker.sv =====
// Port-level checks for the framer, attached to the top level by the bind below.
// Depends only on the top level's ports.
`default_nettype none

module jecf_port_checks (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        item_valid,
	input wire logic        item_ready,
	input wire logic [1:0]  func,
	input wire logic [7:0]  data_byte,
	input wire logic        res_valid,
	input wire logic        res_ready,
	input wire logic [7:0]  out_byte,
	input wire logic        last_of_run,
	input wire logic [31:0] byte_count
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(out_byte)
			&& $stable(last_of_run) && $stable(byte_count))
		else $error("Stalled result changed.");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> byte_count != 32'd0)
		else $error("Result shows a zero byte count.");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && !last_of_run |=> res_valid)
		else $error("Output run broke before its last byte.");

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> item_ready)
		else $error("Input refused while no result is pending.");

endmodule

bind json_escape_crc16_framer jecf_port_checks u_chk (.*);

`default_nettype wire
